>>> rtl/kscd_pkg.sv
// Shared types, codes and key tables for the set-1 scancode decoder.
`timescale 1ns / 1ps
`default_nettype none

package kscd_pkg;

    // Ring geometry
    localparam int RING_DEPTH_DEF = 256;
    localparam int ENTRY_W        = 8;
    localparam int CHAR_W         = 7;
    localparam int KEY_COUNT      = 58;

    // Input operation codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic REG_OWNER = 1'b0;
    localparam logic REG_TTY   = 1'b1;

    // Scancode values of interest
    localparam logic [6:0] SC_LSHIFT = 7'h2a;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CTRL   = 7'h1d;
    localparam logic [6:0] SC_C      = 7'h2e;
    localparam logic [6:0] SC_LAST   = 7'h39;

    // Characters produced outside the tables
    localparam logic [6:0] CH_CTRL   = 7'h1d;
    localparam logic [6:0] CH_ETX    = 7'h03;
    localparam logic [6:0] CH_NONE   = 7'h00;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TTY   = 2'd0,
        KIND_EVENT = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    // Control from the decode stage to the ring
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    // Status from the ring to the decode stage
    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_sts;

    localparam logic [CHAR_W-1:0] PLAIN_TBL [KEY_COUNT] = '{
        7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2d, 7'h3d, 7'h7f, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
        7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00, 7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] SHIFT_TBL [KEY_COUNT] = '{
        7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
        7'h28, 7'h29, 7'h5f, 7'h2b, 7'h7f, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
        7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00, 7'h00, 7'h20
    };

    // Translate a key code; zero means the key has no character
    function automatic logic [CHAR_W-1:0] key_char(input logic [6:0] code,
                                                   input logic       shift);
        logic [CHAR_W-1:0] ch;
        ch = CH_NONE;
        if (code <= SC_LAST) begin
            ch = shift ? SHIFT_TBL[code[5:0]] : PLAIN_TBL[code[5:0]];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kscd_in_if.sv
// Input channel: scancode byte or read request.
`timescale 1ns / 1ps
`default_nettype none

interface kscd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] scan_byte;

    modport source (output valid, output op, output scan_byte, input ready);
    modport sink   (input valid, input op, input scan_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/kscd_out_if.sv
// Output channel: terminal character, dequeued event or empty report.
`timescale 1ns / 1ps
`default_nettype none

interface kscd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [6:0] char_code;
    logic       key_pressed;

    modport source (output valid, output out_kind, output char_code,
                    output key_pressed, input ready);
    modport sink   (input valid, input out_kind, input char_code,
                    input key_pressed, output ready);
endinterface

`default_nettype wire

>>> rtl/kscd_ring.sv
// Event ring: storage, read and write pointers, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kscd_ring #(
    parameter int RING_DEPTH = kscd_pkg::RING_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  kscd_pkg::t_ring_ctl            i_ctl,
    input  wire  [kscd_pkg::ENTRY_W-1:0]   i_wr_data,
    output kscd_pkg::t_ring_sts            o_sts,
    output logic [kscd_pkg::ENTRY_W-1:0]   o_rd_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [kscd_pkg::ENTRY_W-1:0] r_mem [RING_DEPTH];
    logic [PTR_W-1:0]             r_rd_ptr;
    logic [PTR_W-1:0]             r_wr_ptr;
    logic [PTR_W-1:0]             n_rd_ptr;
    logic [PTR_W-1:0]             n_wr_ptr;
    logic [kscd_pkg::ENTRY_W-1:0] r_rd_data;

    // Wrap each pointer at the last entry
    assign n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
    assign n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;

    // One slot stays free so that full and empty differ
    assign o_sts.empty = (r_rd_ptr == r_wr_ptr);
    assign o_sts.full  = (n_wr_ptr == r_rd_ptr);
    assign o_rd_data   = r_rd_data;

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            if (i_ctl.pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_ctl.push) begin
                r_wr_ptr <= n_wr_ptr;
            end
        end
    end

    // Write an event; capture the head entry on a pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (i_ctl.pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/keyboard_scancode_decoder_fifo.sv
// Top level: set-1 scancode decoder with terminal output and event ring.
//
//   Channel   Direction  Handshake             Word
//   i_in      in         valid/ready           op, scan_byte
//   o_out     out        valid/ready           out_kind, char_code, key_pressed
//   APB       in         psel/penable/pwrite   owner_attached @0x0, tty_attached @0x4
//
// One word enters per cycle while the decode stage is not held. A word is held in
// the input register, is decoded there, and its result (if any) is registered in
// the output register once the output is free.
// A dequeued event reads the ring through its registered read port in that
// same decode cycle.
// Reset (synchronous, active low) clears flags, pointers and both valid bits;
// ring contents are not cleared. A stalled output holds the decode stage,
// and input ready drops only while that stage holds a word it cannot retire.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_decoder_fifo #(
    parameter int RING_DEPTH = kscd_pkg::RING_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    kscd_in_if.sink     i_in,
    kscd_out_if.source  o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic r_owner;
    logic r_tty;

    // Input register
    logic       r_s1_valid;
    logic       r_s1_op;
    logic [7:0] r_s1_byte;

    // Modifier flags
    logic r_shift;
    logic r_ctrl;
    logic n_shift;
    logic n_ctrl;

    // Output register
    logic                r_out_valid;
    kscd_pkg::t_kind     r_out_kind;
    logic [6:0]          r_out_char;
    logic                r_out_pressed;
    logic                r_out_from_ring;

    // Decode stage
    logic                out_free;
    logic                s1_fire;
    logic                has_res;
    kscd_pkg::t_kind     res_kind;
    logic [6:0]          res_char;
    logic                res_pressed;
    logic                res_from_ring;
    logic [6:0]          code;
    logic                rel;
    logic [6:0]          ch;
    logic                is_mod_code;

    kscd_pkg::t_ring_ctl                ring_ctl;
    kscd_pkg::t_ring_sts                ring_sts;
    logic [kscd_pkg::ENTRY_W-1:0]       ring_wr_data;
    logic [kscd_pkg::ENTRY_W-1:0]       ring_rd_data;

    // APB: always ready, reads return the selected register
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        prdata[0] = (paddr[2] == kscd_pkg::REG_TTY) ? r_tty : r_owner;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= 1'b0;
            r_tty   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == kscd_pkg::REG_TTY) begin
                r_tty <= pwdata[0];
            end else begin
                r_owner <= pwdata[0];
            end
        end
    end

    // Handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    // Load input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_op   <= i_in.op;
            r_s1_byte <= i_in.scan_byte;
        end
    end

    // Update modifier flags from the current byte
    assign code = r_s1_byte[6:0];
    assign rel  = r_s1_byte[7];
    assign is_mod_code = (code == kscd_pkg::SC_LSHIFT) || (code == kscd_pkg::SC_RSHIFT);
    assign n_shift = is_mod_code ? !rel : r_shift;
    assign n_ctrl  = (code == kscd_pkg::SC_CTRL) ? !rel : r_ctrl;
    assign ch      = kscd_pkg::key_char(code, n_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
        end else if (s1_fire && (r_s1_op == kscd_pkg::OP_SCAN)) begin
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
        end
    end

    // Decode one word: terminal character, queue push, or pop (empty report when the ring is empty)
    always_comb begin
        has_res       = 1'b0;
        res_kind      = kscd_pkg::KIND_TTY;
        res_char      = kscd_pkg::CH_NONE;
        res_pressed   = 1'b0;
        res_from_ring = 1'b0;
        ring_ctl      = '0;
        ring_wr_data  = {!rel, (ch != kscd_pkg::CH_NONE) ? ch : kscd_pkg::CH_CTRL};
        if (r_s1_op == kscd_pkg::OP_READ) begin
            if (r_owner) begin
                has_res = 1'b1;
                if (ring_sts.empty) begin
                    res_kind = kscd_pkg::KIND_EMPTY;
                end else begin
                    res_kind      = kscd_pkg::KIND_EVENT;
                    res_from_ring = 1'b1;
                    ring_ctl.pop  = s1_fire;
                end
            end
        end else if (!r_owner) begin
            if (r_tty && !rel) begin
                if ((code == kscd_pkg::SC_C) && n_ctrl) begin
                    has_res     = 1'b1;
                    res_char    = kscd_pkg::CH_ETX;
                    res_pressed = 1'b1;
                end else if (ch != kscd_pkg::CH_NONE) begin
                    has_res     = 1'b1;
                    res_char    = ch;
                    res_pressed = 1'b1;
                end
            end
        end else if ((code <= kscd_pkg::SC_LAST) && !ring_sts.full &&
                     ((ch != kscd_pkg::CH_NONE) || (code == kscd_pkg::SC_CTRL))) begin
            ring_ctl.push = s1_fire;
        end
    end

    kscd_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ring_ctl),
        .i_wr_data (ring_wr_data),
        .o_sts     (ring_sts),
        .o_rd_data (ring_rd_data)
    );

    // Load or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_fire && has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && has_res) begin
            r_out_kind      <= res_kind;
            r_out_char      <= res_char;
            r_out_pressed   <= res_pressed;
            r_out_from_ring <= res_from_ring;
        end
    end

    // Ring events take their payload from the ring read register
    assign o_out.valid       = r_out_valid;
    assign o_out.out_kind    = r_out_kind;
    assign o_out.char_code   = r_out_from_ring ? ring_rd_data[6:0] : r_out_char;
    assign o_out.key_pressed = r_out_from_ring ? ring_rd_data[7] : r_out_pressed;

endmodule

`default_nettype wire

>>> rtl/kscd_check.sv
// Port-level checks for the scancode decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kscd_check (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [1:0] i_out_kind,
    input wire [6:0] i_char_code,
    input wire       i_key_pressed
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // Terminal characters are always presses
    a_tty_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == kscd_pkg::KIND_TTY)) |-> i_key_pressed)
        else $error("terminal character without press flag");

    // Empty reports carry a zero payload
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == kscd_pkg::KIND_EMPTY))
            |-> ((i_char_code == kscd_pkg::CH_NONE) && !i_key_pressed))
        else $error("empty report with nonzero payload");

    // Reset drains the output
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind keyboard_scancode_decoder_fifo kscd_check u_kscd_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.out_kind),
    .i_char_code   (o_out.char_code),
    .i_key_pressed (o_out.key_pressed)
);

`default_nettype wire
